### design/wcs_pkg.sv
// wcs_pkg: shared types and constants for the windowed cube-sum block.
// Used by every module of the block but wcs_checker; no dependencies of its own.
package wcs_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);

  localparam int WIN_W      = 13;
  localparam int SHIFT_W    = 6;
  localparam int ROUND_W    = 31;
  localparam int COEF_W     = 16;
  localparam int MAG_W      = COEF_W + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int CUBE_W     = 3 * MAG_W;
  localparam int SUM_W      = 64;
  localparam int NUM_BANDS  = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SHIFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ROUND  = 3'd5;

  typedef struct packed {
    logic [WIN_W-1:0] left;
    logic [WIN_W-1:0] right;
    logic [WIN_W-1:0] top;
    logic [WIN_W-1:0] bottom;
  } win_cfg_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [ROUND_W-1:0] round;
  } row_cfg_t;

  // one classified sample, front to back
  typedef struct packed {
    logic [COEF_W-1:0] coef_h;
    logic [COEF_W-1:0] coef_v;
    logic [COEF_W-1:0] coef_d;
    logic              acc;       // sample lies inside the window
    logic              row_close; // row end or frame end
    logic              in_range;  // current row inside the window rows
    logic              frame_end;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_CUBE,
    B_ACC,
    B_RND,
    B_SHF,
    B_FOLD,
    B_EMIT
  } back_state_t;

  // |c| of a 16-bit two's complement value; -32768 gives 32768
  function automatic logic [MAG_W-1:0] magnitude(input logic [COEF_W-1:0] c);
    logic [MAG_W-1:0] ext;
    ext = {1'b0, c};
    return c[COEF_W-1] ? MAG_W'((MAG_W'(1) << COEF_W) - ext) : ext;
  endfunction

endpackage

### design/wcs_front.sv
// wcs_front: column/row tracking and window classification of input samples.
// Depends on wcs_pkg.
module wcs_front (
  input  logic              clk,
  input  logic              rst,
  input  wcs_pkg::win_cfg_t win,
  input  logic              accept,
  input  logic [15:0]       coef_h,
  input  logic [15:0]       coef_v,
  input  logic [15:0]       coef_d,
  input  logic              row_end,
  input  logic              frame_end,
  output wcs_pkg::item_t    item
);
  import wcs_pkg::*;

  localparam int CCMP_W = (COL_W > WIN_W) ? COL_W : WIN_W;
  localparam int RCMP_W = (ROW_W > WIN_W) ? ROW_W : WIN_W;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic             row_in;
  logic             col_in;
  logic             close;

  assign row_in = (row_count < ROW_W'(MAX_HEIGHT)) &&
                  (RCMP_W'(row_count) >= RCMP_W'(win.top)) &&
                  (RCMP_W'(row_count) <  RCMP_W'(win.bottom));
  assign col_in = (col_count < COL_W'(MAX_WIDTH)) &&
                  (CCMP_W'(col_count) >= CCMP_W'(win.left)) &&
                  (CCMP_W'(col_count) <  CCMP_W'(win.right));
  assign close  = row_end | frame_end;

  always_comb begin
    item.coef_h    = coef_h;
    item.coef_v    = coef_v;
    item.coef_d    = coef_d;
    item.acc       = row_in & col_in;
    item.row_close = close;
    item.in_range  = row_in;
    item.frame_end = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col_count <= '0;
        row_count <= '0;
      end else if (close) begin
        col_count <= '0;
        if (row_count < ROW_W'(MAX_HEIGHT)) row_count <= row_count + 1'b1;
      end else if (col_count < COL_W'(MAX_WIDTH)) begin
        col_count <= col_count + 1'b1;
      end
    end
  end

endmodule

### design/wcs_fifo.sv
// wcs_fifo: short queue of classified samples between front and back.
// Depends on wcs_pkg.
module wcs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wcs_pkg::item_t push_data,
  output logic           full,
  input  logic           pop,
  output wcs_pkg::item_t pop_data,
  output logic           empty
);
  import wcs_pkg::*;

  item_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= PTR_W'((32'(wr_ptr) + 1) % FIFO_DEPTH);
      if (pop)  rd_ptr <= PTR_W'((32'(rd_ptr) + 1) % FIFO_DEPTH);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### design/wcs_back.sv
// wcs_back: cube, row and frame accumulation of queued samples, result register.
// Depends on wcs_pkg.
module wcs_back (
  input  logic              clk,
  input  logic              rst,
  input  wcs_pkg::row_cfg_t rcfg,
  input  logic              empty,
  input  wcs_pkg::item_t    head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       total_h,
  output logic [63:0]       total_v,
  output logic [63:0]       total_d
);
  import wcs_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  item_t             ent;
  logic [MAG_W-1:0]  mag       [NUM_BANDS];
  logic [SQ_W-1:0]   sq        [NUM_BANDS];
  logic [CUBE_W-1:0] cube      [NUM_BANDS];
  logic [SUM_W-1:0]  row_sum   [NUM_BANDS];
  logic [SUM_W-1:0]  rnd       [NUM_BANDS];
  logic [SUM_W-1:0]  frame_sum [NUM_BANDS];
  logic [COEF_W-1:0] head_coef [NUM_BANDS];
  logic              emit_ok;
  logic              do_sq;
  logic              do_cube;
  logic              do_acc;
  logic              do_rnd;
  logic              do_shf;
  logic              do_fold;
  logic              do_emit;

  assign head_coef[0] = head.coef_h;
  assign head_coef[1] = head.coef_v;
  assign head_coef[2] = head.coef_d;
  assign emit_ok      = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!empty) state_next = B_SQ;
      B_SQ:   state_next = B_CUBE;
      B_CUBE: state_next = B_ACC;
      B_ACC: begin
        if (ent.row_close && ent.in_range) state_next = B_RND;
        else if (ent.frame_end)            state_next = B_EMIT;
        else                               state_next = B_IDLE;
      end
      B_RND:  state_next = B_SHF;
      B_SHF:  state_next = B_FOLD;
      B_FOLD: state_next = ent.frame_end ? B_EMIT : B_IDLE;
      B_EMIT: if (emit_ok) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    do_sq   = 1'b0;
    do_cube = 1'b0;
    do_acc  = 1'b0;
    do_rnd  = 1'b0;
    do_shf  = 1'b0;
    do_fold = 1'b0;
    do_emit = 1'b0;
    unique case (state)
      B_IDLE: pop     = !empty;
      B_SQ:   do_sq   = 1'b1;
      B_CUBE: do_cube = 1'b1;
      B_ACC:  do_acc  = 1'b1;
      B_RND:  do_rnd  = 1'b1;
      B_SHF:  do_shf  = 1'b1;
      B_FOLD: do_fold = 1'b1;
      B_EMIT: do_emit = emit_ok;
      default: ;
    endcase
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (pop) ent <= head;
    for (int b = 0; b < NUM_BANDS; b++) begin
      if (pop)     mag[b]  <= magnitude(head_coef[b]);
      if (do_sq)   sq[b]   <= SQ_W'(mag[b]) * SQ_W'(mag[b]);
      if (do_cube) cube[b] <= CUBE_W'(sq[b]) * CUBE_W'(mag[b]);
      if (do_rnd)  rnd[b]  <= row_sum[b] + SUM_W'(rcfg.round);
      else if (do_shf) rnd[b] <= rnd[b] >> rcfg.shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        row_sum[b]   <= '0;
        frame_sum[b] <= '0;
      end
    end else begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        if (do_acc) begin
          // a row outside the window rows still clears its (zero) sum
          if (ent.row_close && !ent.in_range) row_sum[b] <= '0;
          else if (ent.acc)                   row_sum[b] <= row_sum[b] + SUM_W'(cube[b]);
        end
        if (do_fold) begin
          row_sum[b]   <= '0;
          frame_sum[b] <= frame_sum[b] + rnd[b];
        end
        if (do_emit) frame_sum[b] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst)                        out_valid <= 1'b0;
    else if (do_emit)               out_valid <= 1'b1;
    else if (out_valid && !out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      total_h <= frame_sum[0];
      total_v <= frame_sum[1];
      total_d <= frame_sum[2];
    end
  end

endmodule

### design/windowed_cube_sum_three_bands_top.sv
// windowed_cube_sum_three_bands_top: config registers, front, queue and back.
// Depends on wcs_pkg, wcs_front, wcs_fifo, wcs_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in      | input     | in_valid/in_stall  | coef_h, coef_v, coef_d, row_end,
//           |           |                    | frame_end
//   out     | output    | out_valid/out_stall| total_h, total_v, total_d
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// For each sample the back end pops it, squares, cubes and row-adds; when it
// closes a row inside the window rows it then rounds, shifts and frame-adds,
// and on frame end it emits the result, waiting while a stalled result is pending.
// The front takes one sample per cycle into a 4-entry queue; in_stall is high
// only while that queue is full. rst is synchronous and clears counters,
// sums, queue and the config registers to their defaults. cfg_ready is
// always high.
module windowed_cube_sum_three_bands_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] coef_h,
  input  logic [15:0] coef_v,
  input  logic [15:0] coef_d,
  input  logic        row_end,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] total_h,
  output logic [63:0] total_v,
  output logic [63:0] total_d,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [wcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wcs_pkg::*;

  win_cfg_t win;
  row_cfg_t rcfg;
  item_t    item;
  item_t    head;
  logic     full;
  logic     empty;
  logic     pop;
  logic     accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.left    <= '0;
      win.right   <= WIN_W'(4096);
      win.top     <= '0;
      win.bottom  <= WIN_W'(4096);
      rcfg.shift  <= '0;
      rcfg.round  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIN_LEFT:   win.left   <= cfg_data[WIN_W-1:0];
        REG_WIN_RIGHT:  win.right  <= cfg_data[WIN_W-1:0];
        REG_WIN_TOP:    win.top    <= cfg_data[WIN_W-1:0];
        REG_WIN_BOTTOM: win.bottom <= cfg_data[WIN_W-1:0];
        REG_ROW_SHIFT:  rcfg.shift <= cfg_data[SHIFT_W-1:0];
        REG_ROW_ROUND:  rcfg.round <= cfg_data[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  wcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .accept    (accept),
    .coef_h    (coef_h),
    .coef_v    (coef_v),
    .coef_d    (coef_d),
    .row_end   (row_end),
    .frame_end (frame_end),
    .item      (item)
  );

  wcs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (item),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  wcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rcfg      (rcfg),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .total_h   (total_h),
    .total_v   (total_v),
    .total_d   (total_d)
  );

endmodule

### design/wcs_checker.sv
// wcs_checker: port-level checks on the windowed cube-sum block, bound to its top.
// Depends on windowed_cube_sum_three_bands_top (port names only).
module wcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] total_h,
  input logic [63:0] total_v,
  input logic [63:0] total_d
);

  // reset leaves the queue empty and no result pending
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(total_h) && $stable(total_v) && $stable(total_d))
    else $error("stalled result changed");

endmodule

bind windowed_cube_sum_three_bands_top wcs_checker u_wcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .total_h   (total_h),
  .total_v   (total_v),
  .total_d   (total_d)
);
